### hw/rtl/bhdr_pkg.sv
// ----------------------------------------------------------------------------
// bhdr_pkg
// Shared types and constants for the block hash delta range finder.
// ----------------------------------------------------------------------------
`default_nettype none

package bhdr_pkg;

    localparam int unsigned REF_DEPTH_DEF = 4096;

    typedef enum logic [0:0] {
        OP_LOAD = 1'b0,
        OP_CMP  = 1'b1
    } bhdr_kind_t;

    // one decoded item as it sits in the queue between front and back
    typedef struct packed {
        bhdr_kind_t  kind;
        logic [63:0] block_offset;
        logic [63:0] block_end;
        logic [31:0] block_length;
        logic [63:0] block_hash;
        logic        last_block;
    } bhdr_op_t;

    // control between front and queue
    typedef struct packed {
        logic push;
        logic full;
    } bhdr_qctl_t;

endpackage

`default_nettype wire

### hw/rtl/bhdr_if.sv
// ----------------------------------------------------------------------------
// bhdr_if
// Valid/ready channels: new-file block descriptors in, changed ranges out.
// ----------------------------------------------------------------------------
`default_nettype none

interface bhdr_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [63:0] block_offset;
    logic [31:0] block_length;
    logic [63:0] block_hash;
    logic        last_block;

    modport source (output valid, cmd, block_offset, block_length, block_hash,
                    last_block, input ready);
    modport sink   (input valid, cmd, block_offset, block_length, block_hash,
                    last_block, output ready);
endinterface

interface bhdr_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] range_start;
    logic [63:0] range_end;
    logic        final_range;

    modport source (output valid, range_start, range_end, final_range,
                    input ready);
    modport sink   (input valid, range_start, range_end, final_range,
                    output ready);
endinterface

`default_nettype wire

### hw/rtl/block_hash_delta_ranges.sv
// ----------------------------------------------------------------------------
// block_hash_delta_ranges
// Changed byte ranges of a new file from per-block hashes against a store
// of old-file block hashes.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  blk_in    in   valid/ready    cmd, block_offset, block_length, block_hash,
//                                last_block
//  rng_out   out  valid/ready    range_start, range_end, final_range
//
//  One transfer per cycle sustained while rng_out is ready; a range is valid on
//  rng_out once the closing block has passed the queue and output register. The
//  store's read port is registered and addressed by the pointer's next value, so
//  each compare sees the entry the pointer names. rst_n clears counts, pointer
//  and run state; the hash store is not cleared. A stalled rng_out holds the
//  output register; the two-entry queue keeps blk_in ready until it fills.
// ----------------------------------------------------------------------------
`default_nettype none

module block_hash_delta_ranges #(
    parameter int unsigned REF_DEPTH = bhdr_pkg::REF_DEPTH_DEF
) (
    input  wire        clk,
    input  wire        rst_n,
    bhdr_in_if.sink    blk_in,
    bhdr_out_if.source rng_out
);
    import bhdr_pkg::*;

    bhdr_qctl_t front_qctl;
    bhdr_qctl_t queue_qctl;
    bhdr_op_t   push_entry;
    bhdr_op_t   q_entry;
    logic       q_valid;
    logic       q_pop;

    bhdr_front u_front (
        .blk_in   (blk_in),
        .qctl_in  (queue_qctl),
        .qctl_out (front_qctl),
        .entry    (push_entry)
    );

    bhdr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .qctl_in    (front_qctl),
        .qctl_out   (queue_qctl),
        .push_entry (push_entry),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_entry    (q_entry)
    );

    bhdr_back #(
        .REF_DEPTH (REF_DEPTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_entry (q_entry),
        .rng_out (rng_out)
    );

endmodule

`default_nettype wire

### hw/rtl/bhdr_front.sv
// ----------------------------------------------------------------------------
// bhdr_front
// Accepts block descriptors, sorts loads from compares, precomputes the end.
// ----------------------------------------------------------------------------
`default_nettype none

module bhdr_front (
    bhdr_in_if.sink                blk_in,
    input  bhdr_pkg::bhdr_qctl_t   qctl_in,
    output bhdr_pkg::bhdr_qctl_t   qctl_out,
    output bhdr_pkg::bhdr_op_t     entry
);
    import bhdr_pkg::*;

    assign blk_in.ready = !qctl_in.full;

    always_comb
    begin
        qctl_out.full = qctl_in.full;
        qctl_out.push = blk_in.valid && !qctl_in.full;
    end

    always_comb
    begin
        entry.kind         = blk_in.cmd ? OP_CMP : OP_LOAD;
        entry.block_offset = blk_in.block_offset;
        // wraps mod 2^64
        entry.block_end    = blk_in.block_offset + {32'd0, blk_in.block_length};
        entry.block_length = blk_in.block_length;
        entry.block_hash   = blk_in.block_hash;
        entry.last_block   = blk_in.last_block;
    end

endmodule

`default_nettype wire

### hw/rtl/bhdr_queue.sv
// ----------------------------------------------------------------------------
// bhdr_queue
// Two-entry queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module bhdr_queue (
    input  wire                    clk,
    input  wire                    rst_n,
    input  bhdr_pkg::bhdr_qctl_t   qctl_in,
    output bhdr_pkg::bhdr_qctl_t   qctl_out,
    input  bhdr_pkg::bhdr_op_t     push_entry,
    output logic                   q_valid,
    input  wire                    q_pop,
    output bhdr_pkg::bhdr_op_t     q_entry
);
    import bhdr_pkg::*;

    bhdr_op_t   slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       do_push, do_pop;

    assign do_push = qctl_in.push;
    assign do_pop  = q_pop && (fill_reg != 2'd0);

    always_comb
    begin
        qctl_out.push = qctl_in.push;
        qctl_out.full = (fill_reg == 2'd2);
    end

    assign q_valid = (fill_reg != 2'd0);
    assign q_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
            fill_next = fill_reg + 2'd1;
        else if (!do_push && do_pop)
            fill_next = fill_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

`default_nettype wire

### hw/rtl/bhdr_back.sv
// ----------------------------------------------------------------------------
// bhdr_back
// Reference store, hash compare, run tracking and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bhdr_back #(
    parameter int unsigned REF_DEPTH = bhdr_pkg::REF_DEPTH_DEF
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  q_valid,
    output logic                 q_pop,
    input  bhdr_pkg::bhdr_op_t   q_entry,
    bhdr_out_if.source           rng_out
);
    import bhdr_pkg::*;

    localparam int unsigned AW = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;
    localparam int unsigned CW = $clog2(REF_DEPTH + 1);

    logic [63:0]   ref_mem [REF_DEPTH];
    logic [63:0]   rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic          run_open_reg, run_open_next;
    logic          tail_open_reg, tail_open_next;
    logic [63:0]   first_reg, first_next;
    logic [63:0]   end_reg, end_next;

    logic          out_valid_reg, out_valid_next;
    logic [63:0]   out_start_reg, out_start_next;
    logic [63:0]   out_end_reg, out_end_next;
    logic          out_final_reg, out_final_next;

    logic          active;
    logic          match;
    logic          emit;

    assign q_pop  = q_valid && (!out_valid_reg || rng_out.ready);
    assign active = (ptr_reg < count_reg);
    assign match  = (rd_data_reg == q_entry.block_hash);

    assign rng_out.valid       = out_valid_reg;
    assign rng_out.range_start = out_start_reg;
    assign rng_out.range_end   = out_end_reg;
    assign rng_out.final_range = out_final_reg;

    always_comb
    begin
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        run_open_next  = run_open_reg;
        tail_open_next = tail_open_reg;
        first_next     = first_reg;
        end_next       = end_reg;
        wr_en          = 1'b0;
        wr_addr        = count_reg[AW-1:0];
        emit           = 1'b0;
        out_start_next = out_start_reg;
        out_end_next   = out_end_reg;
        out_final_next = out_final_reg;

        if (q_pop)
        begin
            case (q_entry.kind)
                OP_LOAD:
                begin
                    if (count_reg < CW'(REF_DEPTH))
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                end
                OP_CMP:
                begin
                    if (active)
                    begin
                        if (match)
                        begin
                            ptr_next = ptr_reg + CW'(1);
                            if (run_open_reg)
                            begin
                                emit           = 1'b1;
                                out_start_next = first_reg;
                                out_end_next   = end_reg;
                                out_final_next = q_entry.last_block;
                                run_open_next  = 1'b0;
                            end
                        end
                        else if (run_open_reg)
                            end_next = end_reg + {32'd0, q_entry.block_length};
                        else
                        begin
                            run_open_next = 1'b1;
                            first_next    = q_entry.block_offset;
                            end_next      = q_entry.block_end;
                        end
                        if (q_entry.last_block && run_open_next)
                        begin
                            emit           = 1'b1;
                            out_start_next = first_next;
                            out_end_next   = end_next;
                            out_final_next = 1'b1;
                        end
                    end
                    else
                    begin
                        if (!tail_open_reg)
                        begin
                            tail_open_next = 1'b1;
                            first_next     = q_entry.block_offset;
                        end
                        if (q_entry.last_block)
                        begin
                            emit           = 1'b1;
                            out_start_next = first_next;
                            out_end_next   = q_entry.block_end;
                            out_final_next = 1'b1;
                        end
                    end
                    if (q_entry.last_block)
                    begin
                        count_next     = '0;
                        ptr_next       = '0;
                        run_open_next  = 1'b0;
                        tail_open_next = 1'b0;
                        first_next     = '0;
                        end_next       = '0;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (emit)
            out_valid_next = 1'b1;
        else if (rng_out.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // read port tracks the pointer the next compare will use
    assign rd_addr = ptr_next[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            ref_mem[wr_addr] <= q_entry.block_hash;
        if (wr_en && (wr_addr == rd_addr))
            rd_data_reg <= q_entry.block_hash;
        else
            rd_data_reg <= ref_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ptr_reg       <= '0;
            run_open_reg  <= 1'b0;
            tail_open_reg <= 1'b0;
            first_reg     <= '0;
            end_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            run_open_reg  <= run_open_next;
            tail_open_reg <= tail_open_next;
            first_reg     <= first_next;
            end_reg       <= end_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_start_reg <= out_start_next;
        out_end_reg   <= out_end_next;
        out_final_reg <= out_final_next;
    end

endmodule

`default_nettype wire
